/* rtl/tydag_pkg.sv */
// Shared types and constants of the tiled YUV detile address generator.
// No dependencies; every other file of the block uses it.
`default_nettype none

package tydag_pkg;

	localparam int DIM_W   = 13;	// frame dimension registers
	localparam int COORD_W = 12;	// column and row of a byte position
	localparam int OFS_W   = 25;	// buffer byte offsets

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd64;
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd32;

	// Frame geometry derived from the two registers
	typedef struct packed {
		logic [DIM_W-1:0] w;		// effective width
		logic [DIM_W-1:0] h;		// effective luma height
		logic [DIM_W-1:0] h_half;	// chroma line count
		logic [DIM_W-1:0] wt_even;	// tile columns, rounded up to even
		logic [DIM_W-1:0] ht_luma;	// tile rows of the luma plane
		logic [DIM_W-1:0] ht_chroma;	// tile rows of the chroma plane
		logic [OFS_W-1:0] luma_size;	// padded luma plane in the tiled buffer
		logic [OFS_W-1:0] wh;		// luma plane in the linear buffer
	} geom_t;

endpackage

`default_nettype wire

/* rtl/tydag_item_if.sv */
// Channel for byte positions going into the address generator.
// Depends on tydag_pkg for field widths.
`default_nettype none

interface tydag_item_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [tydag_pkg::COORD_W-1:0] col;
	logic [tydag_pkg::COORD_W-1:0] line;

	modport source (output valid, output func, output col, output line, input ready);
	modport sink   (input valid, input func, input col, input line, output ready);
endinterface

`default_nettype wire

/* rtl/tydag_result_if.sv */
// Channel for source and destination offsets leaving the address generator.
// Depends on tydag_pkg for field widths.
`default_nettype none

interface tydag_result_if;
	logic                        valid;
	logic                        ready;
	logic [tydag_pkg::OFS_W-1:0] src_offset;
	logic [tydag_pkg::OFS_W-1:0] dst_offset;
	logic                        out_of_range;

	modport source (output valid, output src_offset, output dst_offset, output out_of_range,
		input ready);
	modport sink   (input valid, input src_offset, input dst_offset, input out_of_range,
		output ready);
endinterface

`default_nettype wire

/* rtl/tydag_cfg.sv */
// Frame size registers and the registered frame geometry derived from them.
// Depends on tydag_pkg.
`default_nettype none

module tydag_cfg #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int TILE_COLS  = 64,
	parameter int TILE_ROWS  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [tydag_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [tydag_pkg::DIM_W-1:0]       wr_data,
	output tydag_pkg::geom_t                       geom
);

	localparam int LOG_TC   = $clog2(TILE_COLS);
	localparam int LOG_TR   = $clog2(TILE_ROWS);
	localparam int LOG_TILE = LOG_TC + LOG_TR;
	localparam int DW       = tydag_pkg::DIM_W;
	localparam int OW       = tydag_pkg::OFS_W;

	logic [DW-1:0]    width_q;
	logic [DW-1:0]    height_q;
	tydag_pkg::geom_t geom_q;

	// Clamp to the maximum, then round down to even
	function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v, input int maxv);
		logic [DW-1:0] d;
		d = ({1'b0, v} > (DW+1)'(maxv)) ? DW'(maxv) : v;
		return {d[DW-1:1], 1'b0};
	endfunction

	function automatic tydag_pkg::geom_t derive(input logic [DW-1:0] w_raw,
		input logic [DW-1:0] h_raw);
		tydag_pkg::geom_t g;
		logic [DW-1:0]    wt;
		logic [2*DW-1:0]  tiles;
		logic [OW-1:0]    tiles_rnd;
		logic [2*DW-1:0]  area;
		g.w         = eff_dim(w_raw, MAX_WIDTH);
		g.h         = eff_dim(h_raw, MAX_HEIGHT);
		g.h_half    = g.h >> 1;
		wt          = ((g.w - DW'(1)) >> LOG_TC) + DW'(1);
		g.wt_even   = (wt + DW'(1)) & ~DW'(1);
		g.ht_luma   = ((g.h - DW'(1)) >> LOG_TR) + DW'(1);
		g.ht_chroma = ((g.h_half - DW'(1)) >> LOG_TR) + DW'(1);
		tiles       = g.wt_even * g.ht_luma;
		// pad the luma plane to whole groups of four tiles
		tiles_rnd   = (OW'(tiles) + OW'(3)) & ~OW'(3);
		g.luma_size = tiles_rnd << LOG_TILE;
		area        = g.w * g.h;
		g.wh        = OW'(area);
		return g;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tydag_pkg::RST_FRAME_WIDTH;
			height_q <= tydag_pkg::RST_FRAME_HEIGHT;
			geom_q   <= derive(tydag_pkg::RST_FRAME_WIDTH, tydag_pkg::RST_FRAME_HEIGHT);
		end else begin
			if (wr_en) begin
				case (wr_index)
					tydag_pkg::REG_FRAME_WIDTH: begin
						width_q <= wr_data;
					end
					tydag_pkg::REG_FRAME_HEIGHT: begin
						height_q <= wr_data;
					end
					default: begin
					end
				endcase
			end
			geom_q <= derive(width_q, height_q);
		end
	end

	assign geom = geom_q;

endmodule

`default_nettype wire

/* rtl/tydag_tile.sv */
// Input register and tile placement stage: range check, zig-zag tile index,
// byte within tile and the row product of the linear offset. Depends on tydag_pkg.
`default_nettype none

module tydag_tile #(
	parameter int TILE_COLS = 64,
	parameter int TILE_ROWS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en_s1,
	input  wire logic                                   en_s2,
	input  wire logic                                   in_valid,
	input  wire logic                                   in_func,
	input  wire logic [tydag_pkg::COORD_W-1:0]          in_col,
	input  wire logic [tydag_pkg::COORD_W-1:0]          in_line,
	input  tydag_pkg::geom_t                            geom,
	output logic                                        valid_s1,
	output logic                                        valid_s2,
	output logic                                        oor_s2,
	output logic                                        func_s2,
	output logic [tydag_pkg::OFS_W-1:0]                 pos_s2,
	output logic [$clog2(TILE_COLS)+$clog2(TILE_ROWS)-1:0] intra_s2,
	output logic [tydag_pkg::OFS_W-1:0]                 line_w_s2,
	output logic [tydag_pkg::COORD_W-1:0]               col_s2
);

	localparam int LOG_TC   = $clog2(TILE_COLS);
	localparam int LOG_TR   = $clog2(TILE_ROWS);
	localparam int LOG_TILE = LOG_TC + LOG_TR;
	localparam int CW       = tydag_pkg::COORD_W;
	localparam int DW       = tydag_pkg::DIM_W;
	localparam int OW       = tydag_pkg::OFS_W;
	localparam int TXW      = CW - LOG_TC;
	localparam int TYW      = CW - LOG_TR;

	logic          func_s1;
	logic [CW-1:0] col_s1;
	logic [CW-1:0] line_s1;

	logic [CW-1:0]       scol;
	logic [TXW-1:0]      tx;
	logic [TYW-1:0]      ty;
	logic [DW-1:0]       ht;
	logic [DW-1:0]       rows;
	logic                oor;
	logic [TYW-1:0]      ty_pair;
	logic [TYW+DW-1:0]   pair_prod;
	logic [OW-1:0]       tx_ext;
	logic [OW-1:0]       adj;
	logic [OW-1:0]       pos;
	logic [LOG_TILE-1:0] intra;
	logic [CW+DW-1:0]    line_w;

	always_comb begin
		// chroma swaps the bytes of each U/V pair
		scol      = col_s1 ^ CW'(func_s1);
		tx        = scol[CW-1:LOG_TC];
		ty        = line_s1[CW-1:LOG_TR];
		ht        = func_s1 ? geom.ht_chroma : geom.ht_luma;
		rows      = func_s1 ? geom.h_half : geom.h;
		oor       = !(DW'(col_s1) < geom.w) || !(DW'(line_s1) < rows);
		ty_pair   = {ty[TYW-1:1], 1'b0};
		pair_prod = ty_pair * geom.wt_even;
		tx_ext    = OW'(tx);
		// zig-zag: odd tile rows and the even rows that have a partner below
		if (ty[0]) begin
			adj = (tx_ext & ~OW'(3)) + OW'(2);
		end else if (!ht[0] || (DW'(ty) != (ht - DW'(1)))) begin
			adj = (tx_ext + OW'(2)) & ~OW'(3);
		end else begin
			adj = '0;
		end
		pos    = tx_ext + OW'(pair_prod) + adj;
		intra  = {line_s1[LOG_TR-1:0], scol[LOG_TC-1:0]};
		line_w = line_s1 * geom.w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			func_s1 <= in_func;
			col_s1  <= in_col;
			line_s1 <= in_line;
		end
		if (en_s2) begin
			oor_s2    <= oor;
			func_s2   <= func_s1;
			pos_s2    <= pos;
			intra_s2  <= intra;
			line_w_s2 <= OW'(line_w);
			col_s2    <= col_s1;
		end
	end

endmodule

`default_nettype wire

/* rtl/tydag_sum.sv */
// Result register: adds plane bases, tile offsets and byte offsets into the
// final source and destination offsets. Depends on tydag_pkg.
`default_nettype none

module tydag_sum #(
	parameter int TILE_COLS = 64,
	parameter int TILE_ROWS = 32
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      en_s3,
	input  wire logic                                      valid_s2,
	input  wire logic                                      oor_s2,
	input  wire logic                                      func_s2,
	input  wire logic [tydag_pkg::OFS_W-1:0]               pos_s2,
	input  wire logic [$clog2(TILE_COLS)+$clog2(TILE_ROWS)-1:0] intra_s2,
	input  wire logic [tydag_pkg::OFS_W-1:0]               line_w_s2,
	input  wire logic [tydag_pkg::COORD_W-1:0]             col_s2,
	input  tydag_pkg::geom_t                               geom,
	output logic                                           valid_s3,
	output logic [tydag_pkg::OFS_W-1:0]                    src_s3,
	output logic [tydag_pkg::OFS_W-1:0]                    dst_s3,
	output logic                                           oor_s3
);

	localparam int LOG_TILE = $clog2(TILE_COLS) + $clog2(TILE_ROWS);
	localparam int OW       = tydag_pkg::OFS_W;

	logic [OW-1:0] src_base;
	logic [OW-1:0] dst_base;
	logic [OW-1:0] src;
	logic [OW-1:0] dst;

	always_comb begin
		src_base = func_s2 ? geom.luma_size : '0;
		dst_base = func_s2 ? geom.wh : '0;
		src      = src_base + (pos_s2 << LOG_TILE) + OW'(intra_s2);
		dst      = dst_base + line_w_s2 + OW'(col_s2);
		// drop both offsets outside the plane
		if (oor_s2) begin
			src = '0;
			dst = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			src_s3 <= src;
			dst_s3 <= dst;
			oor_s3 <= oor_s2;
		end
	end

endmodule

`default_nettype wire

/* rtl/tiled_yuv_detile_address_gen_unit.sv */
// Top level of the tiled NV12 to linear NV21 detile address generator.
// Depends on tydag_pkg, tydag_item_if, tydag_result_if, tydag_cfg, tydag_tile, tydag_sum.
//
//   channel   dir   handshake      word
//   item      in    valid/ready    func, col, line
//   result    out   valid/ready    src_offset, dst_offset, out_of_range
//   wr_*      in    wr_en only     wr_index, wr_data
//
// One word per cycle while the sink keeps ready high; an item passes the input
// register, the tile placement stage and the result register in turn before its
// result is presented.
// Stages advance independently, so bubbles close up and an item can be taken
// while the result register waits on a stalled sink, if an earlier stage is empty.
// Reset clears the valid bits and loads a 64 x 32 frame; the frame geometry
// register follows a write in the next cycle.
`default_nettype none

module tiled_yuv_detile_address_gen_unit #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int TILE_COLS  = 64,
	parameter int TILE_ROWS  = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	tydag_item_if.sink                           item,
	tydag_result_if.source                       result,
	input  wire logic                            wr_en,
	input  wire logic [tydag_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [tydag_pkg::DIM_W-1:0]     wr_data
);

	localparam int LOG_TILE = $clog2(TILE_COLS) + $clog2(TILE_ROWS);

	tydag_pkg::geom_t              geom;
	logic                          en_s1;
	logic                          en_s2;
	logic                          en_s3;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          valid_s3;
	logic                          oor_s2;
	logic                          func_s2;
	logic [tydag_pkg::OFS_W-1:0]   pos_s2;
	logic [LOG_TILE-1:0]           intra_s2;
	logic [tydag_pkg::OFS_W-1:0]   line_w_s2;
	logic [tydag_pkg::COORD_W-1:0] col_s2;

	// a stage loads when it is empty or the stage after it moves
	assign en_s3      = !valid_s3 || result.ready;
	assign en_s2      = !valid_s2 || en_s3;
	assign en_s1      = !valid_s1 || en_s2;
	assign item.ready = en_s1;
	assign result.valid = valid_s3;

	tydag_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.TILE_COLS (TILE_COLS),
		.TILE_ROWS (TILE_ROWS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.geom    (geom)
	);

	tydag_tile #(
		.TILE_COLS(TILE_COLS),
		.TILE_ROWS(TILE_ROWS)
	) u_tile (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s1    (en_s1),
		.en_s2    (en_s2),
		.in_valid (item.valid),
		.in_func  (item.func),
		.in_col   (item.col),
		.in_line  (item.line),
		.geom     (geom),
		.valid_s1 (valid_s1),
		.valid_s2 (valid_s2),
		.oor_s2   (oor_s2),
		.func_s2  (func_s2),
		.pos_s2   (pos_s2),
		.intra_s2 (intra_s2),
		.line_w_s2(line_w_s2),
		.col_s2   (col_s2)
	);

	tydag_sum #(
		.TILE_COLS(TILE_COLS),
		.TILE_ROWS(TILE_ROWS)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s3    (en_s3),
		.valid_s2 (valid_s2),
		.oor_s2   (oor_s2),
		.func_s2  (func_s2),
		.pos_s2   (pos_s2),
		.intra_s2 (intra_s2),
		.line_w_s2(line_w_s2),
		.col_s2   (col_s2),
		.geom     (geom),
		.valid_s3 (valid_s3),
		.src_s3   (result.src_offset),
		.dst_s3   (result.dst_offset),
		.oor_s3   (result.out_of_range)
	);

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for the tiled NV12 to linear NV21 detile address generator.
// Needs tydag_pkg, tydag_item_if, tydag_result_if and the unit under test.
`timescale 1ns / 100ps

module tb_top;

	localparam int DIM_W     = tydag_pkg::DIM_W;
	localparam int COORD_W   = tydag_pkg::COORD_W;
	localparam int OFS_W     = tydag_pkg::OFS_W;
	localparam int REG_IDX_W = tydag_pkg::REG_IDX_W;

	localparam int TILE_W  = 64;
	localparam int TILE_H  = 32;
	localparam int MAX_DIM = 4096;
	localparam int PHASE_WORDS = 125;
	localparam int N_PHASES    = 8;
	localparam int HOLD_OFF_CYCLES = 60;

	typedef struct packed {
		logic [OFS_W-1:0] src_offset;
		logic [OFS_W-1:0] dst_offset;
		logic             out_of_range;
	} offsets_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_WORD_LIT} row_kind_t;

	// ROW_CFG: arg_a/arg_b are width/height; otherwise column/line
	typedef struct packed {
		row_kind_t        kind;
		logic             func;
		logic [DIM_W-1:0] arg_a;
		logic [DIM_W-1:0] arg_b;
		offsets_t         want;
	} stim_row_t;

	typedef enum logic [1:0] {
		TRAFFIC_STEADY, TRAFFIC_SRC_GAPS, TRAFFIC_SNK_STALLS, TRAFFIC_BOTH
	} traffic_t;

	localparam offsets_t OUTSIDE = '{src_offset: '0, dst_offset: '0, out_of_range: 1'b1};
	localparam offsets_t NO_LIT  = '0;

	localparam int N_DIRECTED = 27;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ROW_WORD_LIT, 1'b0, 13'd0,    13'd0,    '{25'd0, 25'd0, 1'b0}},
		'{ROW_WORD_LIT, 1'b0, 13'd63,   13'd31,   '{25'd2047, 25'd2047, 1'b0}},
		'{ROW_WORD_LIT, 1'b0, 13'd64,   13'd0,    OUTSIDE},
		'{ROW_WORD_LIT, 1'b0, 13'd0,    13'd32,   OUTSIDE},
		'{ROW_WORD_LIT, 1'b1, 13'd0,    13'd0,    '{25'd8193, 25'd2048, 1'b0}},
		'{ROW_WORD,     1'b1, 13'd63,   13'd15,   NO_LIT},
		'{ROW_WORD_LIT, 1'b1, 13'd0,    13'd16,   OUTSIDE},
		'{ROW_WORD_LIT, 1'b0, 13'd4095, 13'd4095, OUTSIDE},
		// above the maximum and odd: clamps to 4096 x 4096
		'{ROW_CFG,      1'b0, 13'd8191, 13'd8191, NO_LIT},
		'{ROW_WORD,     1'b0, 13'd4095, 13'd4095, NO_LIT},
		'{ROW_WORD,     1'b1, 13'd4095, 13'd2047, NO_LIT},
		'{ROW_WORD_LIT, 1'b1, 13'd0,    13'd2048, OUTSIDE},
		'{ROW_WORD,     1'b0, 13'd1234, 13'd3000, NO_LIT},
		'{ROW_WORD,     1'b0, 13'd100,  13'd40,   NO_LIT},
		// rounds to an empty frame
		'{ROW_CFG,      1'b0, 13'd1,    13'd1,    NO_LIT},
		'{ROW_WORD_LIT, 1'b0, 13'd0,    13'd0,    OUTSIDE},
		'{ROW_WORD_LIT, 1'b1, 13'd0,    13'd0,    OUTSIDE},
		'{ROW_CFG,      1'b0, 13'd67,   13'd99,   NO_LIT},
		'{ROW_WORD,     1'b0, 13'd65,   13'd97,   NO_LIT},
		'{ROW_WORD_LIT, 1'b0, 13'd66,   13'd0,    OUTSIDE},
		'{ROW_WORD,     1'b1, 13'd65,   13'd48,   NO_LIT},
		'{ROW_WORD_LIT, 1'b1, 13'd0,    13'd49,   OUTSIDE},
		// odd tile-column count and odd luma tile-row count
		'{ROW_CFG,      1'b0, 13'd130,  13'd70,   NO_LIT},
		'{ROW_WORD,     1'b0, 13'd129,  13'd69,   NO_LIT},
		'{ROW_WORD,     1'b0, 13'd0,    13'd64,   NO_LIT},
		'{ROW_WORD,     1'b1, 13'd128,  13'd34,   NO_LIT},
		'{ROW_WORD,     1'b0, 13'd70,   13'd33,   NO_LIT}
	};

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [DIM_W-1:0] wr_data;

	tydag_item_if   item_ch ();
	tydag_result_if result_ch ();

	tiled_yuv_detile_address_gen_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	logic [DIM_W-1:0] cfg_width;
	logic [DIM_W-1:0] cfg_height;
	offsets_t expected_offsets [$];
	traffic_t traffic;
	logic hold_off_tgl;
	int mismatch_count;
	int words_luma, words_chroma, words_outside, frame_sizes, results_seen;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint unsigned clamp_even(logic [DIM_W-1:0] v);
		longint unsigned d;
		d = 64'(v);
		if (d > MAX_DIM)
			d = MAX_DIM;
		return d & ~64'd1;
	endfunction

	// zig-zag position of a tile over an even tile-column count
	function automatic longint unsigned tile_slot(longint unsigned tx, longint unsigned ty,
		longint unsigned wtiles, longint unsigned htiles);
		longint unsigned pos;
		pos = tx + (ty & ~64'd1) * wtiles;
		if ((ty & 64'd1) != 0)
			pos += (tx & ~64'd3) + 2;
		else if ((htiles & 64'd1) == 0 || ty != htiles - 1)
			pos += (tx + 2) & ~64'd3;
		return pos;
	endfunction

	function automatic offsets_t predict_offsets(logic func, logic [COORD_W-1:0] col,
		logic [COORD_W-1:0] line);
		longint unsigned w, h, rows, wt_even, ht_luma, ht_chroma, tile_bytes, group;
		longint unsigned luma_bytes, scol, src, dst;
		offsets_t r;
		w = clamp_even(cfg_width);
		h = clamp_even(cfg_height);
		rows = func ? h / 2 : h;
		r = '0;
		if (col >= w || line >= rows) begin
			r.out_of_range = 1'b1;
			return r;
		end
		tile_bytes = TILE_W * TILE_H;
		group = 4 * tile_bytes;
		wt_even = (((w - 1) / TILE_W + 1) + 1) & ~64'd1;
		ht_luma = (h - 1) / TILE_H + 1;
		if (!func) begin
			src = tile_slot(col / TILE_W, line / TILE_H, wt_even, ht_luma) * tile_bytes
				+ (line % TILE_H) * TILE_W + (col % TILE_W);
			dst = line * w + col;
		end else begin
			ht_chroma = (h / 2 - 1) / TILE_H + 1;
			scol = col ^ 64'd1;
			luma_bytes = wt_even * ht_luma * tile_bytes;
			luma_bytes = ((luma_bytes + group - 1) / group) * group;
			src = luma_bytes
				+ tile_slot(scol / TILE_W, line / TILE_H, wt_even, ht_chroma) * tile_bytes
				+ (line % TILE_H) * TILE_W + (scol % TILE_W);
			dst = w * h + line * w + col;
		end
		r.src_offset = src[OFS_W-1:0];
		r.dst_offset = dst[OFS_W-1:0];
		return r;
	endfunction

	task automatic wait_drained();
		while (expected_offsets.size() != 0)
			@(posedge clk);
	endtask

	// Leaves valid high after the word is taken; the next call lowers or reloads it.
	task automatic push_word(logic func, logic [COORD_W-1:0] col, logic [COORD_W-1:0] line,
		offsets_t want);
		int pct;
		pct = (traffic == TRAFFIC_SRC_GAPS) ? 45 : (traffic == TRAFFIC_BOTH) ? 6 : 0;
		while ($urandom_range(0, 99) < pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func  <= func;
		item_ch.col   <= col;
		item_ch.line  <= line;
		do
			@(posedge clk);
		while (!item_ch.ready);
		expected_offsets.push_back(want);
		if (want.out_of_range)
			words_outside++;
		else if (func)
			words_chroma++;
		else
			words_luma++;
	endtask

	task automatic write_frame(logic [DIM_W-1:0] width, logic [DIM_W-1:0] height);
		item_ch.valid <= 1'b0;
		wait_drained();
		// let the pipeline empty behind the last result
		repeat (4) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= tydag_pkg::REG_FRAME_WIDTH;
		wr_data  <= width;
		@(posedge clk);
		cfg_width = width;
		wr_index <= tydag_pkg::REG_FRAME_HEIGHT;
		wr_data  <= height;
		@(posedge clk);
		cfg_height = height;
		wr_en <= 1'b0;
		// geometry register follows in the next cycle
		@(posedge clk);
		frame_sizes++;
	endtask

	// Result side: check accepted words, then drive ready for the next edge.
	initial begin
		int hold_left;
		logic hold_seen;
		logic ready_nxt;
		offsets_t want;
		hold_left = 0;
		hold_seen = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_offsets.size() == 0) begin
					mismatch_count++;
					$display("%0t: result word with nothing expected (src %0d dst %0d oor %0b)",
						$time, result_ch.src_offset, result_ch.dst_offset,
						result_ch.out_of_range);
				end else begin
					want = expected_offsets.pop_front();
					if (result_ch.src_offset !== want.src_offset) begin
						mismatch_count++;
						$display("%0t: src_offset expected %0d got %0d", $time,
							want.src_offset, result_ch.src_offset);
					end
					if (result_ch.dst_offset !== want.dst_offset) begin
						mismatch_count++;
						$display("%0t: dst_offset expected %0d got %0d", $time,
							want.dst_offset, result_ch.dst_offset);
					end
					if (result_ch.out_of_range !== want.out_of_range) begin
						mismatch_count++;
						$display("%0t: out_of_range expected %0b got %0b", $time,
							want.out_of_range, result_ch.out_of_range);
					end
				end
			end
			if (hold_off_tgl != hold_seen) begin
				hold_seen = hold_off_tgl;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_nxt = 1'b0;
			end else if (traffic == TRAFFIC_SNK_STALLS) begin
				ready_nxt = ($urandom_range(0, 99) >= 45);
			end else if (traffic == TRAFFIC_BOTH) begin
				ready_nxt = ($urandom_range(0, 99) >= 6);
			end else begin
				ready_nxt = 1'b1;
			end
			result_ch.ready <= ready_nxt;
		end
	end

	initial begin
		#2_000_000;
		$display("[tiled_yuv_detile_address_gen_unit] ERROR");
		$finish;
	end

	initial begin
		stim_row_t row;
		logic func;
		logic [COORD_W-1:0] col, line;
		longint unsigned w_eff, rows;
		logic [DIM_W-1:0] pw, ph;
		int roll;
		arst_n   <= 1'b0;
		wr_en    <= 1'b0;
		wr_index <= tydag_pkg::REG_FRAME_WIDTH;
		wr_data  <= '0;
		item_ch.valid <= 1'b0;
		item_ch.func  <= 1'b0;
		item_ch.col   <= '0;
		item_ch.line  <= '0;
		hold_off_tgl  <= 1'b0;
		cfg_width  = tydag_pkg::RST_FRAME_WIDTH;
		cfg_height = tydag_pkg::RST_FRAME_HEIGHT;
		traffic = TRAFFIC_STEADY;
		mismatch_count = 0;
		frame_sizes = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			traffic = traffic_t'(i % 4);
			if (row.kind == ROW_CFG)
				write_frame(row.arg_a, row.arg_b);
			else if (row.kind == ROW_WORD_LIT)
				push_word(row.func, row.arg_a[COORD_W-1:0], row.arg_b[COORD_W-1:0], row.want);
			else
				push_word(row.func, row.arg_a[COORD_W-1:0], row.arg_b[COORD_W-1:0],
					predict_offsets(row.func, row.arg_a[COORD_W-1:0],
						row.arg_b[COORD_W-1:0]));
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: begin pw = 13'd4096; ph = 13'd4096; end
				1: begin pw = 13'd2;    ph = 13'd2;    end
				2: begin pw = 13'd1920; ph = 13'd1080; end
				3: begin pw = 13'd4095; ph = 13'd4095; end
				default: begin
					pw = DIM_W'($urandom_range(2, MAX_DIM));
					ph = DIM_W'($urandom_range(2, MAX_DIM));
				end
			endcase
			traffic = TRAFFIC_STEADY;
			write_frame(pw, ph);
			w_eff = clamp_even(cfg_width);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				traffic = traffic_t'((n / 40 + phase) % 4);
				// long sink hold-off while words keep coming
				if (phase == 0 && n == 5)
					hold_off_tgl <= ~hold_off_tgl;
				// sender pause until the pipeline has drained
				if (phase == 2 && n == 70) begin
					item_ch.valid <= 1'b0;
					wait_drained();
				end
				func = 1'($urandom_range(0, 1));
				rows = func ? clamp_even(cfg_height) / 2 : clamp_even(cfg_height);
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					col  = COORD_W'($urandom_range(0, int'(w_eff) - 1));
					line = COORD_W'($urandom_range(0, int'(rows) - 1));
				end else if (roll < 92) begin
					col  = COORD_W'($urandom_range(0, 1) ? w_eff - 1 : w_eff);
					line = COORD_W'($urandom_range(0, 1) ? rows - 1 : rows);
				end else begin
					col  = COORD_W'($urandom);
					line = COORD_W'($urandom);
				end
				push_word(func, col, line, predict_offsets(func, col, line));
			end
		end

		item_ch.valid <= 1'b0;
		traffic = TRAFFIC_STEADY;
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Checked %0d result words: %0d luma, %0d chroma, %0d outside the plane",
			results_seen, words_luma, words_chroma, words_outside);
		$display("Frame settings used: %0d, with source gaps, sink stalls and a long hold-off",
			frame_sizes);
		if (mismatch_count == 0 && expected_offsets.size() == 0)
			$display("[tiled_yuv_detile_address_gen_unit] OK");
		else
			$display("[tiled_yuv_detile_address_gen_unit] ERROR");
		$finish;
	end

endmodule
